@@ rtl/dvrt_pkg.sv @@
// Shared types, constants and distance helpers for the distance-vector route table.
// No dependencies; imported by distance_vector_route_table.
package dvrt_pkg;

	// Table geometry (node indices are carried in 5-bit fields)
	localparam int NODE_W     = 5;
	localparam int NODE_COUNT = 32;
	localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);

	// Distance arithmetic
	localparam int DIST_BITS = 8;
	localparam int LIMIT_W   = 8;
	localparam int ADV_W     = 8;
	localparam int SUM_W     = ((DIST_BITS > LIMIT_W) ? DIST_BITS : LIMIT_W) + 1;

	typedef logic [DIST_BITS-1:0] dist_t;
	typedef logic [NODE_W-1:0]    node_t;

	localparam logic [SUM_W-1:0] DIST_MAX_W = SUM_W'((1 << DIST_BITS) - 1);
	localparam dist_t            DIST_ONE   = DIST_BITS'(1);

	// Register map
	localparam logic REG_SELF  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [NODE_W-1:0]  SELF_RST  = '0;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(10);

	typedef enum logic [1:0] {
		KIND_UPDATE = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RK_LOST   = 2'd0,
		RK_REACH  = 2'd1,
		RK_STATUS = 2'd2
	} rkind_t;

	// Request and response beats
	typedef struct packed {
		logic [1:0]       kind;
		logic [4:0]       dest_node;
		logic [4:0]       from_node;
		logic [ADV_W-1:0] adv_distance;
	} req_t;

	typedef struct packed {
		logic [1:0] report_kind;
		logic [4:0] node_id;
		logic [4:0] next_hop;
		logic       hop_valid;
		logic       updated;
		logic       last;
	} rsp_t;

	// One table row held in RAM
	typedef struct packed {
		dist_t metric;
		node_t hop;
	} route_t;

	// Saturate a value to the distance range
	function automatic dist_t sat_dist(logic [SUM_W-1:0] v);
		return (v > DIST_MAX_W) ? DIST_MAX_W[DIST_BITS-1:0] : v[DIST_BITS-1:0];
	endfunction

	// Advertised distance plus one hop
	function automatic dist_t sat_inc(logic [ADV_W-1:0] adv);
		logic [SUM_W-1:0] s;
		s = SUM_W'(adv) + SUM_W'(1);
		return sat_dist(s);
	endfunction

	// Cascaded distance: new + old - 1, clamped at both ends
	function automatic dist_t sat_cascade(dist_t a, dist_t b);
		logic [DIST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s == '0) begin
			return '0;
		end
		s = s - (DIST_BITS + 1)'(1);
		return sat_dist(SUM_W'(s));
	endfunction

	// Distance at or above the unreachable limit
	function automatic logic at_limit(dist_t d, logic [LIMIT_W-1:0] lim);
		return SUM_W'(d) >= SUM_W'(lim);
	endfunction

endpackage

@@ rtl/dvrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the route table rows.
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/distance_vector_route_table.sv @@
// Distance-vector route table: presence flags in flops, distance and next hop in one RAM.
// Sequence: lookup reads its entry, then gives its status beat; update and erase apply
// the request to the entry, then run the cascade sweep (one RAM row per cycle through
// the shared add/compare unit), then one response beat per cycle while rsp_ready allows.
// Query skips apply; an unchanged update skips the sweep; a new request is taken only when idle.
// Reset clears presence flags and registers only; RAM rows are written before use.
module distance_vector_route_table
	import dvrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_APPLY = 4'b0010,
		S_SWEEP = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [1:0]            kind_q;
	node_t                 dest_q, from_q;
	logic [ADV_W-1:0]      adv_q;
	dist_t                 newd_q, newd_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  ev_vld_s1;
	logic [IDX_W-1:0]      ev_idx_s1;
	logic [NODE_COUNT-1:0] ep_q, hp_q, rep_q;
	node_t                 st_hop_q;
	logic                  st_hv_q, st_upd_q;
	node_t                 self_q;
	logic [LIMIT_W-1:0]    limit_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	// RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	route_t           ram_wdata, ram_rdata;

	// Flag updates from the apply and sweep steps
	logic             flg_en, flg_ep_set, flg_hp_val, rep_set;
	logic [IDX_W-1:0] flg_idx;
	node_t            hop_d;
	logic             hv_d, upd_d;

	logic             req_fire, cfg_wr, emit_go;
	logic             dest_ok;
	logic [IDX_W-1:0] di, low_idx;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign dest_ok   = ({1'b0, dest_q} < (NODE_W + 1)'(NODE_COUNT));
	assign di        = dest_q[IDX_W-1:0];
	assign emit_go   = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);

	// Register read-back
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_SELF:  prdata = 32'(self_q);
			REG_LIMIT: prdata = 32'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q  <= SELF_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SELF:  self_q  <= pwdata[NODE_W-1:0];
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default:   ;
			endcase
		end
	end

	dvrt_ram #(
		.WIDTH($bits(route_t)),
		.DEPTH(NODE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Read the destination row on accept, otherwise the sweep row
	assign ram_raddr = (state_q == S_IDLE) ? req.dest_node[IDX_W-1:0] : cnt_q[IDX_W-1:0];

	// Shared distance unit: apply the request to its entry, or cascade (query: check) one swept row
	always_comb begin
		dist_t nd, lim_d, cur, s;
		logic  ep_d, hp_d, chg, hp_new, from_ok, match;
		nd      = sat_inc(adv_q);
		lim_d   = sat_dist(SUM_W'(limit_q));
		cur     = ram_rdata.metric;
		ep_d    = ep_q[di];
		hp_d    = hp_q[di];
		from_ok = (from_q != self_q);
		chg     = 1'b0;
		hp_new  = hp_d;
		match   = 1'b0;
		s       = '0;

		ram_we     = 1'b0;
		ram_waddr  = di;
		ram_wdata  = ram_rdata;
		flg_en     = 1'b0;
		flg_idx    = di;
		flg_ep_set = 1'b0;
		flg_hp_val = 1'b0;
		rep_set    = 1'b0;
		newd_d     = newd_q;
		hop_d      = '0;
		hv_d       = 1'b0;
		upd_d      = 1'b0;
		state_d    = state_q;

		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_d = (req.kind == KIND_QUERY) ? S_SWEEP : S_APPLY;
				end
			end
			S_APPLY: begin
				state_d = S_EMIT;
				case (kind_q)
					KIND_UPDATE: begin
						ram_wdata.hop = ram_rdata.hop;
						if (dest_ok && dest_q != self_q) begin
							if (!ep_d) begin
								chg    = 1'b1;
								hp_new = from_ok;
								if (from_ok) begin
									ram_wdata.hop = from_q;
								end
							end else if (cur > nd) begin
								chg = 1'b1;
								if (from_ok) begin
									ram_wdata.hop = from_q;
									hp_new        = 1'b1;
								end
							end else if (hp_d && ram_rdata.hop == from_q && cur != nd &&
								!(at_limit(cur, limit_q) && at_limit(nd, limit_q))) begin
								chg = 1'b1;
							end
						end
						// Unreachable or direct neighbor drops the next hop
						if (at_limit(nd, limit_q) || nd == DIST_ONE) begin
							hp_new = 1'b0;
						end
						ram_wdata.metric = nd;
						ram_we         = chg;
						flg_en         = chg;
						flg_ep_set     = 1'b1;
						flg_hp_val     = hp_new;
						rep_set        = chg && at_limit(nd, limit_q);
						upd_d          = chg;
						newd_d         = nd;
						if (chg) begin
							state_d = S_SWEEP;
						end
					end
					KIND_ERASE: begin
						chg            = dest_ok && ep_d;
						ram_wdata.metric = lim_d;
						ram_we         = chg;
						flg_en         = chg;
						flg_ep_set     = 1'b1;
						flg_hp_val     = 1'b0;
						rep_set        = chg;
						upd_d          = chg;
						newd_d         = lim_d;
						if (dest_ok) begin
							state_d = S_SWEEP;
						end
					end
					KIND_LOOKUP: begin
						hv_d  = dest_ok && ep_d && hp_d && !at_limit(cur, limit_q);
						hop_d = hv_d ? ram_rdata.hop : '0;
					end
					default: ;
				endcase
			end
			S_SWEEP: begin
				if (ev_vld_s1) begin
					flg_idx   = ev_idx_s1;
					ram_waddr = ev_idx_s1;
					if (kind_q == KIND_QUERY) begin
						rep_set = ep_q[ev_idx_s1] && !at_limit(cur, limit_q);
					end else begin
						match = ep_q[ev_idx_s1] && hp_q[ev_idx_s1] && ram_rdata.hop == dest_q;
						s     = sat_cascade(newd_q, cur);
						ram_wdata.metric = s;
						ram_we     = match;
						flg_en     = match && at_limit(s, limit_q);
						flg_ep_set = 1'b1;
						flg_hp_val = 1'b0;
						rep_set    = match && at_limit(s, limit_q);
					end
				end
				if (cnt_q == CNT_W'(NODE_COUNT)) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_go && rep_q == '0) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Lowest pending report index
	always_comb begin
		low_idx = '0;
		for (int i = NODE_COUNT - 1; i >= 0; i--) begin
			if (rep_q[i]) begin
				low_idx = IDX_W'(i);
			end
		end
	end

	// Sequencer, flags and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ev_vld_s1   <= 1'b0;
			ep_q        <= '0;
			hp_q        <= '0;
			rep_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Capture the request beat
			if (req_fire) begin
				kind_q   <= req.kind;
				dest_q   <= req.dest_node;
				from_q   <= req.from_node;
				adv_q    <= req.adv_distance;
				cnt_q    <= '0;
				rep_q    <= '0;
				st_hop_q <= '0;
				st_hv_q  <= 1'b0;
				st_upd_q <= 1'b0;
			end

			if (state_q == S_APPLY) begin
				newd_q   <= newd_d;
				st_hop_q <= hop_d;
				st_hv_q  <= hv_d;
				st_upd_q <= upd_d;
				cnt_q    <= '0;
			end

			// Advance the sweep: issue one row read per cycle, evaluate it the next
			if (state_q == S_SWEEP && cnt_q != CNT_W'(NODE_COUNT)) begin
				ev_vld_s1 <= 1'b1;
				ev_idx_s1 <= cnt_q[IDX_W-1:0];
				cnt_q     <= cnt_q + CNT_W'(1);
			end else begin
				ev_vld_s1 <= 1'b0;
			end

			if (flg_en) begin
				if (flg_ep_set) begin
					ep_q[flg_idx] <= 1'b1;
				end
				hp_q[flg_idx] <= flg_hp_val;
			end
			if (rep_set) begin
				rep_q[flg_idx] <= 1'b1;
			end

			// Load the next beat, or drop the response once taken
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
				if (rep_q != '0) begin
					rsp_q.report_kind <= (kind_q == KIND_QUERY) ? RK_REACH : RK_LOST;
					rsp_q.node_id     <= NODE_W'(low_idx);
					rsp_q.next_hop    <= '0;
					rsp_q.hop_valid   <= 1'b0;
					rsp_q.updated     <= 1'b0;
					rsp_q.last        <= 1'b0;
					rep_q[low_idx]    <= 1'b0;
				end else begin
					rsp_q.report_kind <= RK_STATUS;
					rsp_q.node_id     <= (kind_q == KIND_QUERY) ? '0 : dest_q;
					rsp_q.next_hop    <= st_hop_q;
					rsp_q.hop_valid   <= st_hv_q;
					rsp_q.updated     <= st_upd_q;
					rsp_q.last        <= 1'b1;
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A next hop is only ever recorded for a present entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(hp_q & ~ep_q) == '0)
		else $error("next hop flag set on absent entry");

	// The final beat is always the status beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> (rsp.report_kind == RK_STATUS))
		else $error("last beat is not a status beat");

	// Report beats carry no lookup or update flags
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (!rsp.hop_valid && !rsp.updated))
		else $error("report beat carries status flags");

	// Sweep never writes the row it is reading
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && ram_we) |-> (ram_waddr != ram_raddr))
		else $error("sweep read and write collide");

endmodule
